// File: design/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;

  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_NEG = 3'd4,
    OP_INC = 3'd5,
    OP_DEC = 3'd6,
    OP_CMP = 3'd7
  } rau_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_INIT,
    S_MUL,
    S_FORM,
    S_GCD,
    S_DIV_INIT,
    S_DIV,
    S_FIX,
    S_OUT
  } rau_state_t;

  // Product slots of the shared multiplier.
  localparam logic [1:0] SEL_P0 = 2'd0;
  localparam logic [1:0] SEL_P1 = 2'd1;
  localparam logic [1:0] SEL_P2 = 2'd2;

  typedef struct packed {
    logic       load;
    logic       mul_init;
    logic [1:0] mul_sel;
    logic       mul_step;
    logic       form;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       fix;
    logic       out_load;
  } rau_cmd_t;

  typedef struct packed {
    rau_op_t op;
    logic    gcd_done;
  } rau_status_t;

endpackage

// File: design/rau_req_if.sv
`timescale 1ns / 1ps
interface rau_req_if;
  logic               valid;
  logic               ready;
  logic        [ 2:0] req_type;
  logic signed [31:0] a_numerator;
  logic        [30:0] a_denominator;
  logic signed [31:0] b_numerator;
  logic        [30:0] b_denominator;

  modport source (output valid, req_type, a_numerator, a_denominator, b_numerator,
                  b_denominator, input ready);
  modport sink (input valid, req_type, a_numerator, a_denominator, b_numerator,
                b_denominator, output ready);
endinterface

// File: design/rau_resp_if.sv
`timescale 1ns / 1ps
interface rau_resp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] res_numerator;
  logic signed [31:0] res_denominator;
  logic               is_less;
  logic               is_greater;
  logic               is_equal;

  modport source (output valid, res_numerator, res_denominator, is_less, is_greater,
                  is_equal, input ready);
  modport sink (input valid, res_numerator, res_denominator, is_less, is_greater,
                is_equal, output ready);
endinterface

// File: design/rau_datapath.sv
`timescale 1ns / 1ps
module rau_datapath #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  logic                clk,
  input  rau_pkg::rau_cmd_t    cmd,
  output rau_pkg::rau_status_t status,
  input  logic        [ 2:0]  req_type,
  input  logic signed [31:0]  a_numerator,
  input  logic        [30:0]  a_denominator,
  input  logic signed [31:0]  b_numerator,
  input  logic        [30:0]  b_denominator,
  output logic signed [31:0]  res_numerator,
  output logic signed [31:0]  res_denominator,
  output logic                is_less,
  output logic                is_greater,
  output logic                is_equal
);
  import rau_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int KW = $clog2(W);

  logic [W-1:0] an_x, ad_x, bn_x, bd_x;

  if (W > 32) begin : g_ext_wide
    assign an_x = {{(W-32){a_numerator[31]}}, a_numerator};
    assign bn_x = {{(W-32){b_numerator[31]}}, b_numerator};
  end else begin : g_ext_narrow
    assign an_x = a_numerator[W-1:0];
    assign bn_x = b_numerator[W-1:0];
  end

  if (W > 31) begin : g_den_wide
    assign ad_x = {{(W-31){1'b0}}, a_denominator};
    assign bd_x = {{(W-31){1'b0}}, b_denominator};
  end else begin : g_den_narrow
    assign ad_x = a_denominator[W-1:0];
    assign bd_x = b_denominator[W-1:0];
  end

  rau_op_t      op_r;
  logic [W-1:0] an_r, ad_r, bn_r, bd_r;
  logic [W-1:0] mcand_r, mplier_r;
  logic [W-1:0] p0_r, p1_r, p2_r;
  logic         n_neg_r, d_neg_r;
  logic [W-1:0] mn_r, md_r, u_r, v_r, g_r;
  logic [KW-1:0] k_r;
  logic [W-1:0] rem_a_r, rem_b_r, qa_r, qb_r;
  logic [W-1:0] fin_n_r, fin_d_r;
  logic         lt_r, gt_r, eq_r;
  logic [W-1:0] out_n_r, out_d_r;
  logic         out_lt_r, out_gt_r, out_eq_r;

  // Fraction formed before reduction: from the products, or from operand a for negate, increment and decrement.
  logic [W-1:0] n_f, d_f, d0;
  always_comb begin
    n_f = '0;
    d_f = '0;
    case (op_r)
      OP_ADD: begin n_f = p0_r + p1_r; d_f = p2_r; end
      OP_SUB: begin n_f = p0_r - p1_r; d_f = p2_r; end
      OP_MUL: begin n_f = p0_r;        d_f = p1_r; end
      OP_DIV: begin
        if (bn_r == '0) begin
          n_f = '0;
          d_f = W'(1);
        end else begin
          n_f = p0_r;
          d_f = p1_r;
        end
      end
      OP_NEG: begin n_f = '0 - an_r;   d_f = ad_r; end
      OP_INC: begin n_f = an_r + ad_r; d_f = ad_r; end
      OP_DEC: begin n_f = an_r - ad_r; d_f = ad_r; end
      default: begin n_f = '0; d_f = '0; end
    endcase
    d0 = (d_f == '0) ? W'(1) : d_f;
  end

  logic [W:0] ta, tb;
  assign ta = {rem_a_r, qa_r[W-1]};
  assign tb = {rem_b_r, qb_r[W-1]};

  logic [W-1:0] n1, d1;
  assign n1 = n_neg_r ? ('0 - qa_r) : qa_r;
  assign d1 = d_neg_r ? ('0 - qb_r) : qb_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= rau_op_t'(req_type);
      an_r <= an_x;
      ad_r <= ad_x;
      bn_r <= bn_x;
      bd_r <= bd_x;
    end

    if (cmd.mul_init) begin
      case (cmd.mul_sel)
        SEL_P0: begin
          mcand_r  <= an_r;
          mplier_r <= (op_r == OP_MUL) ? bn_r : bd_r;
          p0_r     <= '0;
        end
        SEL_P1: begin
          mcand_r  <= ad_r;
          mplier_r <= (op_r == OP_MUL) ? bd_r : bn_r;
          p1_r     <= '0;
        end
        default: begin
          mcand_r  <= ad_r;
          mplier_r <= bd_r;
          p2_r     <= '0;
        end
      endcase
    end

    // Shift-and-add: low word of the product is the same for signed operands.
    if (cmd.mul_step) begin
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
      if (mplier_r[0]) begin
        case (cmd.mul_sel)
          SEL_P0:  p0_r <= p0_r + mcand_r;
          SEL_P1:  p1_r <= p1_r + mcand_r;
          default: p2_r <= p2_r + mcand_r;
        endcase
      end
    end

    if (cmd.form) begin
      n_neg_r <= n_f[W-1];
      d_neg_r <= d0[W-1];
      mn_r    <= n_f[W-1] ? ('0 - n_f) : n_f;
      md_r    <= d0[W-1] ? ('0 - d0) : d0;
      u_r     <= n_f[W-1] ? ('0 - n_f) : n_f;
      v_r     <= d0[W-1] ? ('0 - d0) : d0;
      k_r     <= '0;
      if (op_r == OP_CMP) begin
        fin_n_r <= '0;
        fin_d_r <= '0;
        lt_r    <= $signed(p0_r) < $signed(p1_r);
        gt_r    <= $signed(p1_r) < $signed(p0_r);
        eq_r    <= (an_r == bn_r) && (ad_r == bd_r);
      end else begin
        lt_r <= 1'b0;
        gt_r <= 1'b0;
        eq_r <= 1'b0;
      end
    end

    // Binary gcd: one halving or one subtraction per cycle until u is zero.
    if (cmd.gcd_step) begin
      if (!u_r[0] && !v_r[0]) begin
        u_r <= u_r >> 1;
        v_r <= v_r >> 1;
        k_r <= k_r + KW'(1);
      end else if (!u_r[0]) begin
        u_r <= u_r >> 1;
      end else if (!v_r[0]) begin
        v_r <= v_r >> 1;
      end else if (u_r >= v_r) begin
        u_r <= u_r - v_r;
      end else begin
        v_r <= v_r - u_r;
      end
    end

    if (cmd.div_init) begin
      g_r     <= v_r << k_r;
      rem_a_r <= '0;
      rem_b_r <= '0;
      qa_r    <= mn_r;
      qb_r    <= md_r;
    end

    // Two restoring dividers share the divisor g.
    if (cmd.div_step) begin
      if (ta >= {1'b0, g_r}) begin
        rem_a_r <= W'(ta - {1'b0, g_r});
        qa_r    <= {qa_r[W-2:0], 1'b1};
      end else begin
        rem_a_r <= ta[W-1:0];
        qa_r    <= {qa_r[W-2:0], 1'b0};
      end
      if (tb >= {1'b0, g_r}) begin
        rem_b_r <= W'(tb - {1'b0, g_r});
        qb_r    <= {qb_r[W-2:0], 1'b1};
      end else begin
        rem_b_r <= tb[W-1:0];
        qb_r    <= {qb_r[W-2:0], 1'b0};
      end
    end

    // A denominator still negative moves its sign into the numerator.
    if (cmd.fix) begin
      if (d1[W-1]) begin
        fin_n_r <= '0 - n1;
        fin_d_r <= '0 - d1;
      end else begin
        fin_n_r <= n1;
        fin_d_r <= d1;
      end
    end

    if (cmd.out_load) begin
      out_n_r  <= fin_n_r;
      out_d_r  <= fin_d_r;
      out_lt_r <= lt_r;
      out_gt_r <= gt_r;
      out_eq_r <= eq_r;
    end
  end

  assign status.op       = op_r;
  assign status.gcd_done = (u_r == '0);

  if (W > 32) begin : g_out_wide
    assign res_numerator   = out_n_r[31:0];
    assign res_denominator = out_d_r[31:0];
  end else if (W == 32) begin : g_out_same
    assign res_numerator   = out_n_r;
    assign res_denominator = out_d_r;
  end else begin : g_out_narrow
    assign res_numerator   = {{(32-W){1'b0}}, out_n_r};
    assign res_denominator = {{(32-W){1'b0}}, out_d_r};
  end

  assign is_less    = out_lt_r;
  assign is_greater = out_gt_r;
  assign is_equal   = out_eq_r;

endmodule

// File: design/rau_ctrl.sv
`timescale 1ns / 1ps
module rau_ctrl #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  rau_pkg::rau_status_t status,
  output rau_pkg::rau_cmd_t    cmd
);
  import rau_pkg::*;

  localparam int CW = $clog2(WORD_BITS);
  localparam logic [CW-1:0] LAST = CW'(WORD_BITS - 1);

  rau_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [1:0]    sel_r, sel_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [1:0]    last_sel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sel_r       <= SEL_P0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Add and subtract need a third product for the common denominator.
  assign last_sel = (status.op == OP_ADD || status.op == OP_SUB) ? SEL_P2 : SEL_P1;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.mul_sel   = sel_r;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          sel_nxt   = SEL_P0;
          cnt_nxt   = '0;
          state_nxt = S_MUL_INIT;
        end
      end
      S_MUL_INIT: begin
        if (status.op inside {OP_NEG, OP_INC, OP_DEC}) begin
          state_nxt = S_FORM;
        end else begin
          cmd.mul_init = 1'b1;
          state_nxt    = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + CW'(1);
        if (cnt_r == LAST) begin
          cnt_nxt = '0;
          if (sel_r == last_sel) begin
            state_nxt = S_FORM;
          end else begin
            sel_nxt   = sel_r + 2'd1;
            state_nxt = S_MUL_INIT;
          end
        end
      end
      S_FORM: begin
        cmd.form  = 1'b1;
        state_nxt = (status.op == OP_CMP) ? S_OUT : S_GCD;
      end
      S_GCD: begin
        if (status.gcd_done) begin
          state_nxt = S_DIV_INIT;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CW'(1);
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready)
    else $error("request taken outside idle");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_MUL_INIT))
    else $error("accepted request did not start");

  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == LAST) |=> (state_r == S_FIX))
    else $error("division did not finish after a full word");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("result loaded without valid");
`endif

endmodule

// File: design/rational_arith_unit.sv
`timescale 1ns / 1ps
// Rational arithmetic unit: fraction add, subtract, multiply, divide, negate,
// increment, decrement and compare, with the result reduced by its gcd.
// in_ch carries one request (operation and two fractions) with valid/ready;
// out_ch returns one result per request with valid/ready.
// The block works on one request at a time. After acceptance a request
// passes through the cross products (3 for add and subtract, 2 for
// multiply, divide and compare) from a shared shift-add multiplier that
// retires one multiplier bit per cycle, then through binary gcd steps and a
// reduction division that takes one quotient bit per cycle. Negate,
// increment and decrement skip the multiplier. Compare skips gcd and
// division.
// in_ch.ready is high only while the unit is idle; a new request may be
// taken while the previous result still waits in the output register.
// If the receiver stalls, the result holds and the next one waits before the
// output register. Reset (rst_n low, synchronous) returns to idle and drops
// any pending result.
module rational_arith_unit #(
  parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
  input logic    clk,
  input logic    rst_n,
  rau_req_if.sink   in_ch,
  rau_resp_if.source out_ch
);
  import rau_pkg::*;

  rau_cmd_t    cmd;
  rau_status_t status;
  logic        in_ready;
  logic        out_valid;

  rau_ctrl #(
    .WORD_BITS(WORD_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ch.ready),
    .status   (status),
    .cmd      (cmd)
  );

  rau_datapath #(
    .WORD_BITS(WORD_BITS)
  ) u_datapath (
    .clk            (clk),
    .cmd            (cmd),
    .status         (status),
    .req_type       (in_ch.req_type),
    .a_numerator    (in_ch.a_numerator),
    .a_denominator  (in_ch.a_denominator),
    .b_numerator    (in_ch.b_numerator),
    .b_denominator  (in_ch.b_denominator),
    .res_numerator  (out_ch.res_numerator),
    .res_denominator(out_ch.res_denominator),
    .is_less        (out_ch.is_less),
    .is_greater     (out_ch.is_greater),
    .is_equal       (out_ch.is_equal)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

endmodule
